[hdl/ucer_pkg.sv]
// shared types, request codes and descriptor constants of the ep0 responder
`default_nettype none

package ucer_pkg;

    // largest ep0 packet, bytes
    localparam logic [6:0] MAX_PACKET = 7'd64;

    // line coding after reset: 115200 baud, 1 stop, no parity, 8 bits
    localparam logic [55:0] CODING_RESET = 56'h08_0000_0001_C200;
    localparam logic [9:0]  CODING_BYTES = 10'd7;

    localparam logic [6:0] DEVICE_DESC_LEN = 7'd18;
    localparam logic [6:0] CONFIG_DESC_LEN = 7'd67;

    typedef enum logic [1:0] {
        CMD_BUS_RESET   = 2'd0,
        CMD_SETUP       = 2'd1,
        CMD_OUT_DATA    = 2'd2,
        CMD_IN_COMPLETE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_SEND_CHUNK = 3'd1,
        ACT_SEND_ZLP   = 3'd2,
        ACT_STALL_IN   = 3'd3,
        ACT_STALL_BOTH = 3'd4,
        ACT_ARM_RX     = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        SRC_DEVICE  = 3'd0,
        SRC_CONFIG  = 3'd1,
        SRC_STRING0 = 3'd2,
        SRC_STATUS  = 3'd6,
        SRC_CODING  = 3'd7
    } source_t;

    // bmRequestType bits 6:5
    localparam logic [1:0] KIND_STANDARD = 2'd0;
    localparam logic [1:0] KIND_CLASS    = 2'd1;

    // standard requests
    localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'h01;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'h03;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

    // cdc class requests
    localparam logic [7:0] REQ_SET_CODING         = 8'h20;
    localparam logic [7:0] REQ_GET_CODING         = 8'h21;
    localparam logic [7:0] REQ_SET_CONTROL_LINE   = 8'h22;

    // descriptor types, high byte of wValue
    localparam logic [7:0] DESC_DEVICE = 8'h01;
    localparam logic [7:0] DESC_CONFIG = 8'h02;
    localparam logic [7:0] DESC_STRING = 8'h03;

    localparam logic [7:0] STRING_COUNT = 8'd4;
    localparam logic [6:0] STATUS_LEN   = 7'd2;
    localparam logic [6:0] CODING_LEN   = 7'd7;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
        logic [9:0]  out_count;
        logic [55:0] out_payload;
    } evt_item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [2:0]  source;
        logic [6:0]  offset;
        logic [6:0]  chunk_length;
        logic [6:0]  device_address;
        logic        is_configured;
        logic [55:0] coding_out;
    } res_item_t;

    // what a setup beat asks of the state and of the result
    typedef struct packed {
        action_t    action;
        logic [2:0] source;
        logic [6:0] chunk;
        logic [6:0] remaining;
        logic       load_reply;
        logic       load_address;
        logic       load_config;
        logic       config_value;
    } setup_dec_t;

    function automatic logic [6:0] string_len(input logic [1:0] idx);
        logic [6:0] len;
        case (idx)
            2'd0:    len = 7'd4;
            2'd1:    len = 7'd14;
            2'd2:    len = 7'd38;
            default: len = 7'd10;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hdl/ucer_evt_if.sv]
// event channel: valid/ready with one usb ep0 event per beat
`default_nettype none

interface ucer_evt_if;
    logic                valid;
    logic                ready;
    ucer_pkg::evt_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/ucer_res_if.sv]
// result channel: valid/ready with one responder action per beat
`default_nettype none

interface ucer_res_if;
    logic                valid;
    logic                ready;
    ucer_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/ucer_setup_decoder.sv]
// setup packet decoder: standard and cdc requests, descriptor sizing
`default_nettype none

module ucer_setup_decoder
    import ucer_pkg::*;
(
    input  wire evt_item_t  item,
    output setup_dec_t      dec
);

    logic [7:0] dtype;
    logic [7:0] dindex;
    logic       desc_found;
    logic [2:0] desc_src;
    logic [6:0] desc_len;
    logic [6:0] clamped_len;
    logic [6:0] chunk;

    assign dtype  = item.request_value[15:8];
    assign dindex = item.request_value[7:0];

    always_comb
    begin
        desc_found = 1'b0;
        desc_src   = SRC_DEVICE;
        desc_len   = '0;
        unique case (dtype)
            DESC_DEVICE:
            begin
                desc_found = 1'b1;
                desc_src   = SRC_DEVICE;
                desc_len   = DEVICE_DESC_LEN;
            end
            DESC_CONFIG:
            begin
                desc_found = 1'b1;
                desc_src   = SRC_CONFIG;
                desc_len   = CONFIG_DESC_LEN;
            end
            DESC_STRING:
            begin
                if (dindex < STRING_COUNT)
                begin
                    desc_found = 1'b1;
                    desc_src   = SRC_STRING0 + {1'b0, dindex[1:0]};
                    desc_len   = string_len(dindex[1:0]);
                end
            end
            default:
            begin
                desc_found = 1'b0;
            end
        endcase
    end

    // wLength of zero means no clamp
    always_comb
    begin
        clamped_len = desc_len;
        if (item.request_length != 16'd0 && {9'd0, desc_len} > item.request_length)
        begin
            clamped_len = item.request_length[6:0];
        end
        chunk = (clamped_len > MAX_PACKET) ? MAX_PACKET : clamped_len;
    end

    always_comb
    begin
        dec        = '0;
        dec.action = ACT_STALL_BOTH;
        unique case (item.request_type[6:5])
            KIND_STANDARD:
            begin
                unique case (item.request_code) inside
                    REQ_GET_DESCRIPTOR:
                    begin
                        if (desc_found)
                        begin
                            dec.action     = ACT_SEND_CHUNK;
                            dec.source     = desc_src;
                            dec.chunk      = chunk;
                            dec.remaining  = clamped_len - chunk;
                            dec.load_reply = 1'b1;
                        end
                        else
                        begin
                            dec.action = ACT_STALL_IN;
                        end
                    end
                    REQ_SET_ADDRESS:
                    begin
                        dec.action       = ACT_SEND_ZLP;
                        dec.load_address = 1'b1;
                    end
                    REQ_SET_CONFIGURATION:
                    begin
                        dec.action       = ACT_SEND_ZLP;
                        dec.load_config  = 1'b1;
                        dec.config_value = (item.request_value != 16'd0);
                    end
                    REQ_GET_STATUS:
                    begin
                        dec.action = ACT_SEND_CHUNK;
                        dec.source = SRC_STATUS;
                        dec.chunk  = STATUS_LEN;
                    end
                    REQ_CLEAR_FEATURE, REQ_SET_FEATURE:
                    begin
                        dec.action = ACT_SEND_ZLP;
                    end
                    default:
                    begin
                        dec.action = ACT_STALL_BOTH;
                    end
                endcase
            end
            KIND_CLASS:
            begin
                unique case (item.request_code)
                    REQ_SET_CODING:
                    begin
                        dec.action = ACT_ARM_RX;
                    end
                    REQ_GET_CODING:
                    begin
                        dec.action = ACT_SEND_CHUNK;
                        dec.source = SRC_CODING;
                        dec.chunk  = CODING_LEN;
                    end
                    REQ_SET_CONTROL_LINE:
                    begin
                        dec.action = ACT_SEND_ZLP;
                    end
                    default:
                    begin
                        dec.action = ACT_STALL_BOTH;
                    end
                endcase
            end
            default:
            begin
                dec.action = ACT_STALL_BOTH;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/usb_control_endpoint_responder_core.sv]
// usb cdc endpoint-0 responder: input register, event logic, state and result register
//
//   channel  dir  beat                               modport
//   evt      in   one ep0 event (reset/setup/out/in)  ucer_evt_if.sink
//   res      out  one action for that event           ucer_res_if.source
//
// every event gives exactly one result, through the input and then the result register
// one event per cycle sustained while res.ready holds high; the input register and the
// result register form a two-stage pipe, and all state updates in the single decode cycle
// a stalled result holds in the result register while one more event waits
// in the input register; evt.ready drops only when both are full
// rst_n (async) restores address 0, unconfigured, default line coding
`default_nettype none

module usb_control_endpoint_responder_core
    import ucer_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    ucer_evt_if.sink     evt,
    ucer_res_if.source   res
);

    // input stage
    logic      in_valid_reg;
    evt_item_t in_item_reg;
    logic      advance;

    // responder state
    logic [6:0]  applied_address_reg, applied_address_next;
    logic [6:0]  pending_address_reg, pending_address_next;
    logic        address_waiting_reg, address_waiting_next;
    logic        configured_reg,      configured_next;
    logic [55:0] coding_reg,          coding_next;
    logic [2:0]  reply_source_reg,    reply_source_next;
    logic [6:0]  reply_offset_reg,    reply_offset_next;
    logic [6:0]  reply_remaining_reg, reply_remaining_next;

    // result stage
    logic      res_valid_reg;
    res_item_t res_item_reg, res_item_next;

    setup_dec_t dec;
    logic [6:0] in_chunk;

    assign advance   = in_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !in_valid_reg || advance;
    assign res.valid = res_valid_reg;
    assign res.data  = res_item_reg;

    ucer_setup_decoder u_setup_decoder (
        .item (in_item_reg),
        .dec  (dec)
    );

    assign in_chunk = (reply_remaining_reg > MAX_PACKET) ? MAX_PACKET : reply_remaining_reg;

    always_comb
    begin
        applied_address_next = applied_address_reg;
        pending_address_next = pending_address_reg;
        address_waiting_next = address_waiting_reg;
        configured_next      = configured_reg;
        coding_next          = coding_reg;
        reply_source_next    = reply_source_reg;
        reply_offset_next    = reply_offset_reg;
        reply_remaining_next = reply_remaining_reg;
        res_item_next        = '0;

        unique case (cmd_t'(in_item_reg.command))
            CMD_BUS_RESET:
            begin
                // pending reply and line coding survive a bus reset
                applied_address_next = '0;
                pending_address_next = '0;
                address_waiting_next = 1'b0;
                configured_next      = 1'b0;
                res_item_next.action = ACT_NONE;
            end
            CMD_SETUP:
            begin
                reply_source_next    = dec.load_reply ? dec.source : 3'd0;
                reply_offset_next    = dec.load_reply ? dec.chunk : 7'd0;
                reply_remaining_next = dec.load_reply ? dec.remaining : 7'd0;
                if (dec.load_address)
                begin
                    pending_address_next = in_item_reg.request_value[6:0];
                    address_waiting_next = 1'b1;
                end
                if (dec.load_config)
                begin
                    configured_next = dec.config_value;
                end
                res_item_next.action       = dec.action;
                res_item_next.source       = dec.source;
                res_item_next.chunk_length = dec.chunk;
            end
            CMD_OUT_DATA:
            begin
                if (in_item_reg.out_count == CODING_BYTES)
                begin
                    coding_next = in_item_reg.out_payload;
                end
                res_item_next.action = ACT_SEND_ZLP;
            end
            CMD_IN_COMPLETE:
            begin
                if (address_waiting_reg)
                begin
                    applied_address_next = pending_address_reg;
                    address_waiting_next = 1'b0;
                end
                if (reply_remaining_reg != 7'd0)
                begin
                    reply_offset_next          = reply_offset_reg + in_chunk;
                    reply_remaining_next       = reply_remaining_reg - in_chunk;
                    res_item_next.action       = ACT_SEND_CHUNK;
                    res_item_next.source       = reply_source_reg;
                    res_item_next.offset       = reply_offset_reg;
                    res_item_next.chunk_length = in_chunk;
                end
                else
                begin
                    res_item_next.action = ACT_ARM_RX;
                end
            end
            default:
            begin
                res_item_next.action = ACT_NONE;
            end
        endcase

        res_item_next.device_address = applied_address_next;
        res_item_next.is_configured  = configured_next;
        res_item_next.coding_out     = coding_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            res_valid_reg       <= 1'b0;
            applied_address_reg <= '0;
            pending_address_reg <= '0;
            address_waiting_reg <= 1'b0;
            configured_reg      <= 1'b0;
            coding_reg          <= CODING_RESET;
            reply_source_reg    <= '0;
            reply_offset_reg    <= '0;
            reply_remaining_reg <= '0;
        end
        else
        begin
            if (evt.ready)
            begin
                in_valid_reg <= evt.valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                applied_address_reg <= applied_address_next;
                pending_address_reg <= pending_address_next;
                address_waiting_reg <= address_waiting_next;
                configured_reg      <= configured_next;
                coding_reg          <= coding_next;
                reply_source_reg    <= reply_source_next;
                reply_offset_reg    <= reply_offset_next;
                reply_remaining_reg <= reply_remaining_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (evt.ready && evt.valid)
        begin
            in_item_reg <= evt.data;
        end
        if (advance)
        begin
            res_item_reg <= res_item_next;
        end
    end

`ifndef SYNTHESIS
    // only a chunk carries a source, offset and length
    a_unused_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_item_reg.action != ACT_SEND_CHUNK) |->
        (res_item_reg.source == 3'd0 && res_item_reg.offset == 7'd0 &&
         res_item_reg.chunk_length == 7'd0))
        else $error("non-chunk result carries chunk fields");

    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_item_reg.chunk_length <= MAX_PACKET)
        else $error("chunk longer than max packet");

    // a pending reply never runs past the longest descriptor
    a_reply_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (reply_remaining_reg != 7'd0) |->
        ({1'b0, reply_offset_reg} + {1'b0, reply_remaining_reg} <= {1'b0, CONFIG_DESC_LEN}))
        else $error("pending reply beyond descriptor end");

    // a waiting address leaves only through an in completion or a bus reset
    a_address_release: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(address_waiting_reg) |->
        $past(advance && (in_item_reg.command == CMD_IN_COMPLETE ||
                          in_item_reg.command == CMD_BUS_RESET)))
        else $error("address released without in completion or bus reset");
`endif

endmodule

`default_nettype wire
